/* rtl/i2crts_pkg.sv */
// Shared types, codes and field layout for the I2C register transfer sequencer.
package i2crts_pkg;

    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned ADDR_BITS   = 7;
    localparam int unsigned COUNT_BITS  = 3;
    localparam int unsigned IN_DATA_W   = 64;
    localparam int unsigned IN_USER_W   = 2;
    localparam int unsigned OUT_DATA_W  = 48;

    localparam logic [BYTE_BITS-1:0]  BYTE_MASK = 8'hff;
    localparam logic [COUNT_BITS-1:0] COUNT_MIN = 3'd1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 3'd4;

    // Event kinds carried in tuser
    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_ACK   = 2'd1,
        EV_RX    = 2'd2,
        EV_STOP  = 2'd3
    } ev_t;

    // Transfer phases; codes five to seven are never entered
    typedef enum logic [2:0] {
        PH_ADDR_SENT = 3'd0,
        PH_REG_SENT  = 3'd1,
        PH_RECEIVE   = 3'd2,
        PH_WRITE     = 3'd3,
        PH_WAIT_STOP = 3'd4
    } phase_t;

    // One incoming event
    typedef struct packed {
        ev_t                    mode;
        logic [ADDR_BITS-1:0]   device_addr;
        logic [BYTE_BITS-1:0]   reg_addr;
        logic                   is_read;
        logic [COUNT_BITS-1:0]  byte_count;
        logic [WORD_BITS-1:0]   word_in;
        logic [BYTE_BITS-1:0]   rx_byte;
    } item_t;

    // Sequencer state
    typedef struct packed {
        phase_t                 phase;
        logic                   dir_read;
        logic [ADDR_BITS-1:0]   target_addr;
        logic [BYTE_BITS-1:0]   register_addr;
        logic [COUNT_BITS-1:0]  bytes_left;
        logic [WORD_BITS-1:0]   data_word;
        logic                   idle_flag;
    } seq_state_t;

    // One result
    typedef struct packed {
        logic                   cmd_start;
        logic                   cmd_stop;
        logic                   cmd_ack;
        logic                   cmd_nack;
        logic                   tx_valid;
        logic [BYTE_BITS-1:0]   tx_byte;
        logic                   done_res;
        logic [WORD_BITS-1:0]   word_out;
        logic                   busy_res;
        logic                   error;
    } result_t;

    localparam seq_state_t STATE_RESET = '{
        phase:         PH_ADDR_SENT,
        dir_read:      1'b0,
        target_addr:   '0,
        register_addr: '0,
        bytes_left:    '0,
        data_word:     '0,
        idle_flag:     1'b1
    };

endpackage

/* rtl/i2crts_step.sv */
// Next-state and result logic for one event of the transfer sequencer.
module i2crts_step
(
    input  i2crts_pkg::item_t      item,
    input  i2crts_pkg::seq_state_t cur,
    output i2crts_pkg::seq_state_t nxt,
    output i2crts_pkg::result_t    res
);

    logic [i2crts_pkg::COUNT_BITS-1:0] cnt;
    logic [i2crts_pkg::COUNT_BITS-1:0] left_dec;
    logic [1:0]                        lane;
    logic [i2crts_pkg::BYTE_BITS-1:0]  lane_byte;
    logic [i2crts_pkg::WORD_BITS-1:0]  merged_word;

    // Byte count clamped to 1..4
    always_comb
    begin
        cnt = item.byte_count;
        if (cnt == '0)
        begin
            cnt = i2crts_pkg::COUNT_MIN;
        end
        else if (cnt > i2crts_pkg::COUNT_MAX)
        begin
            cnt = i2crts_pkg::COUNT_MAX;
        end
    end

    // Lane picked by the decremented count, most significant first
    assign left_dec = cur.bytes_left - 3'd1;
    assign lane     = left_dec[1:0];

    always_comb
    begin
        merged_word = cur.data_word;
        case (lane)
            2'd0:
            begin
                lane_byte          = cur.data_word[7:0];
                merged_word[7:0]   = item.rx_byte;
            end
            2'd1:
            begin
                lane_byte          = cur.data_word[15:8];
                merged_word[15:8]  = item.rx_byte;
            end
            2'd2:
            begin
                lane_byte          = cur.data_word[23:16];
                merged_word[23:16] = item.rx_byte;
            end
            default:
            begin
                lane_byte          = cur.data_word[31:24];
                merged_word[31:24] = item.rx_byte;
            end
        endcase
    end

    // Event handling
    always_comb
    begin
        nxt = cur;
        res = '0;
        if (item.mode == i2crts_pkg::EV_START)
        begin
            if (!cur.idle_flag)
            begin
                res.error = 1'b1;
            end
            else
            begin
                nxt.target_addr   = item.device_addr;
                nxt.register_addr = item.reg_addr;
                nxt.dir_read      = item.is_read;
                nxt.bytes_left    = cnt;
                nxt.data_word     = item.word_in;
                nxt.phase         = i2crts_pkg::PH_ADDR_SENT;
                nxt.idle_flag     = 1'b0;
                res.cmd_start     = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = {item.device_addr, 1'b0};
            end
        end
        else if (cur.idle_flag)
        begin
            res.error = 1'b1;
        end
        else
        begin
            case (item.mode)
                i2crts_pkg::EV_ACK:
                begin
                    case (cur.phase)
                        i2crts_pkg::PH_ADDR_SENT:
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = cur.register_addr;
                            nxt.phase    = cur.dir_read ? i2crts_pkg::PH_REG_SENT
                                                        : i2crts_pkg::PH_WRITE;
                        end
                        i2crts_pkg::PH_REG_SENT:
                        begin
                            res.cmd_start = 1'b1;
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = {cur.target_addr, 1'b1};
                            nxt.phase     = i2crts_pkg::PH_RECEIVE;
                        end
                        i2crts_pkg::PH_WRITE:
                        begin
                            if (cur.bytes_left == '0)
                            begin
                                res.error = 1'b1;
                            end
                            else
                            begin
                                nxt.bytes_left = left_dec;
                                res.tx_valid   = 1'b1;
                                res.tx_byte    = lane_byte;
                                if (left_dec == '0)
                                begin
                                    res.cmd_stop = 1'b1;
                                    nxt.phase    = i2crts_pkg::PH_WAIT_STOP;
                                end
                            end
                        end
                        i2crts_pkg::PH_RECEIVE,
                        i2crts_pkg::PH_WAIT_STOP:
                        begin
                            // ack is expected here, nothing to do
                        end
                        default:
                        begin
                            res.error = 1'b1;
                        end
                    endcase
                end
                i2crts_pkg::EV_RX:
                begin
                    if (cur.phase != i2crts_pkg::PH_RECEIVE || cur.bytes_left == '0)
                    begin
                        res.error = 1'b1;
                    end
                    else
                    begin
                        nxt.bytes_left = left_dec;
                        nxt.data_word  = merged_word;
                        if (left_dec != '0)
                        begin
                            res.cmd_ack = 1'b1;
                        end
                        else
                        begin
                            res.cmd_nack = 1'b1;
                            res.cmd_stop = 1'b1;
                            nxt.phase    = i2crts_pkg::PH_WAIT_STOP;
                        end
                    end
                end
                default:
                begin
                    // stop detected
                    if (cur.phase != i2crts_pkg::PH_WAIT_STOP)
                    begin
                        res.error = 1'b1;
                    end
                    else
                    begin
                        res.done_res  = 1'b1;
                        nxt.idle_flag = 1'b1;
                        nxt.phase     = i2crts_pkg::PH_ADDR_SENT;
                    end
                end
            endcase
        end
        res.word_out = nxt.data_word;
        res.busy_res = ~nxt.idle_flag;
    end

endmodule

/* rtl/i2crts_result_reg.sv */
// Output register stage of the sequencer: holds one result until the sink takes it.
module i2crts_result_reg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  i2crts_pkg::result_t                  res,
    output logic                                 can_load,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [i2crts_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic                valid_reg;
    logic                valid_next;
    i2crts_pkg::result_t res_reg;

    assign can_load   = ~valid_reg | m_tready;
    assign valid_next = load | (valid_reg & ~m_tready);

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.error, res_reg.busy_res, res_reg.word_out,
                       res_reg.done_res, res_reg.tx_byte, res_reg.tx_valid,
                       res_reg.cmd_nack, res_reg.cmd_ack, res_reg.cmd_stop,
                       res_reg.cmd_start};

endmodule

/* rtl/i2crts_seq_core.sv */
// I2C register transfer sequencer, top level with input register and state.
// One event is taken per clock, back to back, for as long as the sink keeps
// m_tready high; each event yields exactly one result transaction, passing
// first through the input register and then the result register. The sequencer
// state is updated together with the result register load, which sets
// the one-event-per-clock rate. A start while busy, or an event that does not
// fit the current phase, sets the error bit and leaves the state unchanged.
module i2c_register_transfer_sequencer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // device_addr[6:0] reg_addr[14:7] is_read[15] byte_count[18:16]
    // word_in[50:19] rx_byte[58:51], zero above
    input  logic [i2crts_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode[1:0]
    input  logic [i2crts_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cmd_start[0] cmd_stop[1] cmd_ack[2] cmd_nack[3] tx_valid[4]
    // tx_byte[12:5] done_res[13] word_out[45:14] busy_res[46] error[47]
    output logic [i2crts_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    i2crts_pkg::item_t      item_reg;
    i2crts_pkg::seq_state_t state_reg;
    i2crts_pkg::seq_state_t state_next;
    i2crts_pkg::result_t    step_res;
    logic                   can_load;
    logic                   advance;
    logic                   in_take;

    assign advance       = in_valid_reg & can_load;
    assign s_tready      = ~in_valid_reg | can_load;
    assign in_take       = s_tvalid & s_tready;
    assign in_valid_next = in_take | (in_valid_reg & ~can_load);

    // Input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.mode        <= i2crts_pkg::ev_t'(s_tuser[1:0]);
            item_reg.device_addr <= s_tdata[6:0];
            item_reg.reg_addr    <= s_tdata[14:7];
            item_reg.is_read     <= s_tdata[15];
            item_reg.byte_count  <= s_tdata[18:16];
            item_reg.word_in     <= s_tdata[50:19];
            item_reg.rx_byte     <= s_tdata[58:51];
        end
    end

    // Event logic
    i2crts_step u_step
    (
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2crts_pkg::STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    i2crts_result_reg u_result
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res      (step_res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // An idle sequencer sits in the address phase with nothing pending
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.idle_flag |-> state_reg.phase == i2crts_pkg::PH_ADDR_SENT)
        else $error("idle sequencer outside address phase");

    // An error result never carries a command or a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.error) |->
        !(step_res.cmd_start || step_res.cmd_stop || step_res.cmd_ack ||
          step_res.cmd_nack || step_res.tx_valid))
        else $error("command issued together with error");

    // Errors leave the sequencer state untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.error) |=> $stable(state_reg))
        else $error("state changed on error event");

    // Done always ends the transfer and never comes with ack or nack
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.done_res) |->
        (!step_res.busy_res && !step_res.cmd_ack && !step_res.cmd_nack))
        else $error("done result inconsistent");

endmodule
